// File: sv/eihc_pkg.sv
// Package for the Ethernet/IPv4 header checker: status codes, byte offsets
// and result layout. No dependencies.
`timescale 1ns / 1ps

package eihc_pkg;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_ETHERTYPE = 3'd1;
    localparam logic [2:0] STAT_VER_IHL   = 3'd2;
    localparam logic [2:0] STAT_CSUM      = 3'd3;
    localparam logic [2:0] STAT_TRUNC     = 3'd4;

    // frame layout, byte offsets from the destination MAC
    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] POS_SRC_MAC   = 7'd6;
    localparam logic [POS_W-1:0] POS_ETYPE_HI  = 7'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO  = 7'd13;
    localparam logic [POS_W-1:0] ETH_HDR_BYTES = 7'd14;
    localparam logic [POS_W-1:0] POS_MAX       = 7'd127;

    // offsets inside the IPv4 header
    localparam logic [POS_W-1:0] IP_CSUM_LO = 7'd11;
    localparam logic [POS_W-1:0] IP_SRC_LO  = 7'd12;
    localparam logic [POS_W-1:0] IP_DST_LO  = 7'd16;
    localparam logic [POS_W-1:0] IP_DST_END = 7'd20;

    localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
    localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
    localparam logic [3:0] IP_VERSION4   = 4'd4;
    localparam logic [3:0] IHL_MIN       = 4'd5;

    // result beat: status, dest MAC, src MAC, src IP, dest IP, IHL, pad
    localparam int RES_BITS  = 3 + 48 + 48 + 32 + 32 + 4;
    localparam int RES_BYTES = (RES_BITS + 7) / 8;
    localparam int RES_W     = RES_BYTES * 8;

endpackage

// File: sv/ethernet_ipv4_header_checker_top.sv
// Top level of the Ethernet/IPv4 header checker: byte parser, ones'
// complement checksum and result register. Depends on eihc_pkg.
`timescale 1ns / 1ps

//  channel | dir | ports                         | beat
//  --------+-----+-------------------------------+------------------------------
//  input   | in  | s_tvalid s_tready s_tdata s_tlast | one frame byte, tlast = end
//  result  | out | m_tvalid m_tready m_tdata     | one result per frame
//
//  One byte is taken every cycle; its parse, field capture and checksum add
//  (16-bit add plus end-around carry) settle in the same cycle, and a result
//  lands in the output register on the edge that accepts the byte.
//  Reset (aresetn low, synchronous) clears the parser state and m_tvalid.
//  The input stalls only while a result sits in the output register and the
//  sink holds m_tready low.

module ethernet_ipv4_header_checker_top
    import eihc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // data_byte
    input  logic             s_tlast,   // frame_end
    output logic             m_tvalid,
    input  logic             m_tready,
    // [2:0] status, [50:3] dest_mac_addr, [98:51] src_mac_addr,
    // [130:99] src_ip_addr, [162:131] dest_ip_addr, [166:163] header_words,
    // [167] zero
    output logic [RES_W-1:0] m_tdata
);

    // parser state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             done_reg, done_next;
    logic [47:0]      dmac_reg, dmac_next;
    logic [47:0]      smac_reg, smac_next;
    logic [31:0]      sip_reg, sip_next;
    logic [31:0]      dip_reg, dip_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       hold_reg, hold_next;
    logic [15:0]      csum_reg, csum_next;

    // output register
    logic             m_valid_reg;
    logic [RES_W-1:0] m_data_reg;

    logic             s_fire;
    logic             res_valid;
    logic [2:0]       res_status;
    logic [POS_W-1:0] ip_off;
    logic [15:0]      word;
    logic [16:0]      sum_wide;
    logic [5:0]       last_hdr_off;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign ip_off       = pos_reg - ETH_HDR_BYTES;
    assign word         = {hold_reg, s_tdata};
    // offset of the last header byte: IHL*4-1
    assign last_hdr_off = {ihl_next - 4'd1, 2'b11};

    always_comb begin
        pos_next   = pos_reg;
        done_next  = done_reg;
        dmac_next  = dmac_reg;
        smac_next  = smac_reg;
        sip_next   = sip_reg;
        dip_next   = dip_reg;
        ihl_next   = ihl_reg;
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        csum_next  = csum_reg;
        res_valid  = 1'b0;
        res_status = STAT_OK;
        sum_wide   = '0;

        if (!done_reg) begin
            if (pos_reg < POS_SRC_MAC) begin
                dmac_next = {dmac_reg[39:0], s_tdata};
            end else if (pos_reg < POS_ETYPE_HI) begin
                smac_next = {smac_reg[39:0], s_tdata};
            end else if (pos_reg == POS_ETYPE_HI) begin
                hold_next = s_tdata;
            end else if (pos_reg == POS_ETYPE_LO) begin
                if (hold_reg != ETYPE_HI_IPV4 || s_tdata != ETYPE_LO_IPV4) begin
                    res_valid  = 1'b1;
                    res_status = STAT_ETHERTYPE;
                end
            end else begin
                if (ip_off == '0) begin
                    ihl_next = s_tdata[3:0];
                    if (s_tdata[7:4] != IP_VERSION4 || s_tdata[3:0] < IHL_MIN) begin
                        res_valid  = 1'b1;
                        res_status = STAT_VER_IHL;
                    end
                end
                if (!ip_off[0]) begin
                    hold_next = s_tdata;
                end else begin
                    // checksum word itself counts as zero
                    if (ip_off == IP_CSUM_LO) begin
                        csum_next = word;
                        sum_wide  = {1'b0, sum_reg};
                    end else begin
                        sum_wide  = {1'b0, sum_reg} + {1'b0, word};
                    end
                    sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
                end
                if (ip_off >= IP_SRC_LO && ip_off < IP_DST_LO) begin
                    sip_next = {sip_reg[23:0], s_tdata};
                end else if (ip_off >= IP_DST_LO && ip_off < IP_DST_END) begin
                    dip_next = {dip_reg[23:0], s_tdata};
                end
                if (!res_valid && ihl_next != '0
                        && ip_off == {1'b0, last_hdr_off}) begin
                    res_valid  = 1'b1;
                    res_status = (~sum_next == csum_next) ? STAT_OK : STAT_CSUM;
                end
            end

            if (!res_valid && s_tlast) begin
                res_valid  = 1'b1;
                res_status = STAT_TRUNC;
            end
            if (res_valid) begin
                done_next = 1'b1;
            end else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 7'd1;
            end
        end
    end

    // parser state, advanced per accepted byte; tlast starts a new frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
            dmac_reg <= '0;
            smac_reg <= '0;
            sip_reg  <= '0;
            dip_reg  <= '0;
            ihl_reg  <= '0;
            sum_reg  <= '0;
            hold_reg <= '0;
            csum_reg <= '0;
        end else if (s_fire) begin
            if (s_tlast) begin
                pos_reg  <= '0;
                done_reg <= 1'b0;
                dmac_reg <= '0;
                smac_reg <= '0;
                sip_reg  <= '0;
                dip_reg  <= '0;
                ihl_reg  <= '0;
                sum_reg  <= '0;
                hold_reg <= '0;
                csum_reg <= '0;
            end else begin
                pos_reg  <= pos_next;
                done_reg <= done_next;
                dmac_reg <= dmac_next;
                smac_reg <= smac_next;
                sip_reg  <= sip_next;
                dip_reg  <= dip_next;
                ihl_reg  <= ihl_next;
                sum_reg  <= sum_next;
                hold_reg <= hold_next;
                csum_reg <= csum_next;
            end
        end
    end

    // result register: s_fire implies it is free or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            m_valid_reg <= s_fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            m_data_reg <= {{(RES_W - RES_BITS){1'b0}}, ihl_next, dip_next, sip_next,
                           smac_next, dmac_next, res_status};
        end
    end

`ifndef SYNTHESIS
    // bytes after the result of a frame never produce a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && done_reg |=> !m_tvalid)
        else $error("result produced after frame already reported");

    // end of frame always restarts the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> pos_reg == '0 && !done_reg)
        else $error("parser not cleared after tlast");

    // a passing header always carries a legal IHL
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == STAT_OK |-> m_tdata[166:163] >= IHL_MIN)
        else $error("ok status with short IHL");

    // a frame in progress without a result keeps counting bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_tlast && !done_reg && !res_valid && pos_reg != POS_MAX
        |=> pos_reg == $past(pos_reg) + 7'd1)
        else $error("byte position did not advance");
`endif

endmodule
